### sv/mbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbm_pkg
// Shared widths and field offsets for the Mandelbrot step pipeline.
// ----------------------------------------------------------------------------
package mbm_pkg;

    localparam int LIMB_W    = 32;
    localparam int FIELD_W   = 64;
    localparam int MAG_IO_W  = 2 * FIELD_W;           // hi:lo magnitude
    localparam int CPLX_W    = 1 + 2 * FIELD_W;       // sign, hi, lo
    localparam int IN_BITS   = 4 * CPLX_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 2 * CPLX_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int PIPE_DEPTH = 6;

    // field bases inside the input item
    localparam int IN_C_RE = 0;
    localparam int IN_C_IM = CPLX_W;
    localparam int IN_Z_RE = 2 * CPLX_W;
    localparam int IN_Z_IM = 3 * CPLX_W;

    // field bases inside the result item
    localparam int OUT_RE  = 0;
    localparam int OUT_IM  = CPLX_W;
    localparam int OUT_OVF = 2 * CPLX_W;

    typedef logic [PIPE_DEPTH-1:0] stage_vec_t;

endpackage
`default_nettype wire

### sv/mbm_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbm_mul
// Three-stage truncated multiplier: 32x32 partial products, row sums, final
// column sum with the low fraction limbs dropped.
// ----------------------------------------------------------------------------
module mbm_mul #(
    parameter int LIMBS = 4
) (
    input  wire                          clk,
    input  wire logic [2:0]              en,
    input  wire logic [32*LIMBS-1:0]     a,
    input  wire logic [32*LIMBS-1:0]     b,
    output logic [32*(LIMBS+1)-1:0]      p
);
    import mbm_pkg::*;

    localparam int RW = LIMB_W * (LIMBS + 1);
    localparam int FW = 2 * LIMB_W * LIMBS;

    logic [2*LIMB_W-1:0] pp_reg [LIMBS][LIMBS];
    logic [RW-1:0]       row_reg [LIMBS];
    logic [RW-1:0]       row_next [LIMBS];
    logic [FW-1:0]       full_next;
    logic [RW-1:0]       p_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LIMBS; i++)
        begin
            for (int j = 0; j < LIMBS; j++)
            begin
                if (en[0])
                begin
                    pp_reg[i][j] <= (2*LIMB_W)'(a[LIMB_W*i +: LIMB_W])
                                  * (2*LIMB_W)'(b[LIMB_W*j +: LIMB_W]);
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < LIMBS; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < LIMBS; j++)
            begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (LIMB_W * j));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        full_next = '0;
        for (int i = 0; i < LIMBS; i++)
        begin
            full_next = full_next + (FW'(row_reg[i]) << (LIMB_W * i));
        end
    end

    // keep the integer limb, fraction limbs and carry-out limb
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            p_reg <= full_next[LIMB_W*(LIMBS-1) +: RW];
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

### sv/mbm_sadd.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbm_sadd
// Registered sign-magnitude adder. Sign of a result of zero is left as is.
// ----------------------------------------------------------------------------
module mbm_sadd #(
    parameter int W = 192
) (
    input  wire                clk,
    input  wire logic          en,
    input  wire logic          a_sign,
    input  wire logic [W-1:0]  a_mag,
    input  wire logic          b_sign,
    input  wire logic [W-1:0]  b_mag,
    output logic               r_sign,
    output logic [W-1:0]       r_mag
);
    logic [W:0]   ab_diff;
    logic [W-1:0] ba_diff;
    logic         sign_next;
    logic [W-1:0] mag_next;
    logic         sign_reg;
    logic [W-1:0] mag_reg;

    always_comb
    begin
        ab_diff = {1'b0, a_mag} - {1'b0, b_mag};
        ba_diff = b_mag - a_mag;
        if (a_sign == b_sign)
        begin
            sign_next = a_sign;
            mag_next  = a_mag + b_mag;
        end
        else if (!ab_diff[W])
        begin
            sign_next = a_sign;
            mag_next  = ab_diff[W-1:0];
        end
        else
        begin
            sign_next = b_sign;
            mag_next  = ba_diff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_reg <= sign_next;
            mag_reg  <= mag_next;
        end
    end

    assign r_sign = sign_reg;
    assign r_mag  = mag_reg;

endmodule
`default_nettype wire

### sv/mandelbrot_step_multilimb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_step_multilimb
// One Mandelbrot iteration z' = z*z + c in sign-magnitude fixed point.
// ----------------------------------------------------------------------------
// Six-stage pipeline: input register, three multiplier stages (partial
// products, row sums, column sum), then two sign-magnitude add stages. One
// item is accepted every cycle while the output is not stalled. Each stage
// holds its item while the next is full, so empty stages keep filling during
// an output stall. Magnitudes use the top LIMBS 32-bit limbs of hi:lo;
// unused low limbs of the result are zero. overflow flags an integer part
// beyond 32 bits.
// ----------------------------------------------------------------------------
module mandelbrot_step_multilimb #(
    parameter int LIMBS = 4
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // c_re_sign, c_re_hi, c_re_lo, c_im_sign, c_im_hi, c_im_lo,
    // z_re_sign, z_re_hi, z_re_lo, z_im_sign, z_im_hi, z_im_lo, zero pad
    input  wire logic [mbm_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // new_re_sign, new_re_hi, new_re_lo, new_im_sign, new_im_hi,
    // new_im_lo, overflow, zero pad
    output logic [mbm_pkg::OUT_DATA_W-1:0]        m_tdata
);
    import mbm_pkg::*;

    localparam int MW = LIMB_W * LIMBS;
    localparam int PW = LIMB_W * (LIMBS + 1);
    localparam int W  = LIMB_W * (LIMBS + 2);

    stage_vec_t valid_reg;
    stage_vec_t rdy;

    // hi:lo magnitudes as numbers
    logic [MAG_IO_W-1:0] cr_in, ci_in, zr_in, zi_in;
    logic [MAG_IO_W-1:0] re_out, im_out;

    // stage 0: input register
    logic          cr_s_reg, ci_s_reg, zr_s_reg, zi_s_reg;
    logic [MW-1:0] cr_reg, ci_reg, zr_reg, zi_reg;

    // c values and signs ride along the multiplier stages
    logic          cr_s_d [3];
    logic          ci_s_d [3];
    logic          zs_d [3];
    logic [MW-1:0] cr_d [3];
    logic [MW-1:0] ci_d [3];

    logic [PW-1:0] p_ri, p_rr, p_ii;

    logic          im_s, re1_s, re_s, cr4_s_reg, im5_s_reg;
    logic [W-1:0]  im_m, re1_m, re_m, im5_reg;
    logic [MW-1:0] cr4_reg;

    logic          re_any, im_any, ovf;

    // per-stage ready: a stage moves when it is empty or its successor moves
    always_comb
    begin
        rdy[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || m_tready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[PIPE_DEPTH-1];

    assign cr_in = {s_tdata[IN_C_RE + 1 +: FIELD_W], s_tdata[IN_C_RE + 1 + FIELD_W +: FIELD_W]};
    assign ci_in = {s_tdata[IN_C_IM + 1 +: FIELD_W], s_tdata[IN_C_IM + 1 + FIELD_W +: FIELD_W]};
    assign zr_in = {s_tdata[IN_Z_RE + 1 +: FIELD_W], s_tdata[IN_Z_RE + 1 + FIELD_W +: FIELD_W]};
    assign zi_in = {s_tdata[IN_Z_IM + 1 +: FIELD_W], s_tdata[IN_Z_IM + 1 + FIELD_W +: FIELD_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            cr_s_reg <= s_tdata[IN_C_RE];
            ci_s_reg <= s_tdata[IN_C_IM];
            zr_s_reg <= s_tdata[IN_Z_RE];
            zi_s_reg <= s_tdata[IN_Z_IM];
            cr_reg   <= cr_in[MAG_IO_W-1 -: MW];
            ci_reg   <= ci_in[MAG_IO_W-1 -: MW];
            zr_reg   <= zr_in[MAG_IO_W-1 -: MW];
            zi_reg   <= zi_in[MAG_IO_W-1 -: MW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            cr_s_d[0] <= cr_s_reg;
            ci_s_d[0] <= ci_s_reg;
            zs_d[0]   <= zr_s_reg ^ zi_s_reg;
            cr_d[0]   <= cr_reg;
            ci_d[0]   <= ci_reg;
        end
        for (int k = 1; k < 3; k++)
        begin
            if (rdy[k+1])
            begin
                cr_s_d[k] <= cr_s_d[k-1];
                ci_s_d[k] <= ci_s_d[k-1];
                zs_d[k]   <= zs_d[k-1];
                cr_d[k]   <= cr_d[k-1];
                ci_d[k]   <= ci_d[k-1];
            end
        end
    end

    mbm_mul #(.LIMBS(LIMBS)) u_mul_ri (
        .clk (clk),
        .en  (rdy[3:1]),
        .a   (zr_reg),
        .b   (zi_reg),
        .p   (p_ri)
    );

    mbm_mul #(.LIMBS(LIMBS)) u_mul_rr (
        .clk (clk),
        .en  (rdy[3:1]),
        .a   (zr_reg),
        .b   (zr_reg),
        .p   (p_rr)
    );

    mbm_mul #(.LIMBS(LIMBS)) u_mul_ii (
        .clk (clk),
        .en  (rdy[3:1]),
        .a   (zi_reg),
        .b   (zi_reg),
        .p   (p_ii)
    );

    // stage 4: 2*zr*zi + ci, and zr^2 - zi^2
    mbm_sadd #(.W(W)) u_add_im (
        .clk    (clk),
        .en     (rdy[4]),
        .a_sign (zs_d[2]),
        .a_mag  (W'(p_ri) << 1),
        .b_sign (ci_s_d[2]),
        .b_mag  (W'(ci_d[2])),
        .r_sign (im_s),
        .r_mag  (im_m)
    );

    mbm_sadd #(.W(W)) u_add_re1 (
        .clk    (clk),
        .en     (rdy[4]),
        .a_sign (1'b0),
        .a_mag  (W'(p_rr)),
        .b_sign (1'b1),
        .b_mag  (W'(p_ii)),
        .r_sign (re1_s),
        .r_mag  (re1_m)
    );

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            cr4_s_reg <= cr_s_d[2];
            cr4_reg   <= cr_d[2];
        end
        if (rdy[5])
        begin
            im5_s_reg <= im_s;
            im5_reg   <= im_m;
        end
    end

    // stage 5: + cr
    mbm_sadd #(.W(W)) u_add_re (
        .clk    (clk),
        .en     (rdy[5]),
        .a_sign (re1_s),
        .a_mag  (re1_m),
        .b_sign (cr4_s_reg),
        .b_mag  (W'(cr4_reg)),
        .r_sign (re_s),
        .r_mag  (re_m)
    );

    always_comb
    begin
        re_any = |re_m[MW-1:0];
        im_any = |im5_reg[MW-1:0];
        ovf    = (|re_m[W-1:MW]) || (|im5_reg[W-1:MW]);
        re_out = MAG_IO_W'(re_m[MW-1:0]) << (MAG_IO_W - MW);
        im_out = MAG_IO_W'(im5_reg[MW-1:0]) << (MAG_IO_W - MW);
        m_tdata = '0;
        m_tdata[OUT_RE]                        = re_s && re_any;
        m_tdata[OUT_RE + 1 +: FIELD_W]         = re_out[MAG_IO_W-1 -: FIELD_W];
        m_tdata[OUT_RE + 1 + FIELD_W +: FIELD_W] = re_out[FIELD_W-1:0];
        m_tdata[OUT_IM]                        = im5_s_reg && im_any;
        m_tdata[OUT_IM + 1 +: FIELD_W]         = im_out[MAG_IO_W-1 -: FIELD_W];
        m_tdata[OUT_IM + 1 + FIELD_W +: FIELD_W] = im_out[FIELD_W-1:0];
        m_tdata[OUT_OVF]                       = ovf;
    end

    // the real part's sign never goes out on a zero magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[OUT_RE] && !re_any))
        else $error("negative zero on real part");

    // with the output stalled, input is taken only while some stage is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && !m_tready) |-> !(&valid_reg))
        else $error("input accepted into a full pipeline");

    // an accepted item occupies the first stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted item lost at input stage");

endmodule
`default_nettype wire
